// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("assertion failed");

// condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    `ASSERT_CLK(label, clk, rst_n, !(cond))

`endif

// ===== rtl/core/pscst_pkg.sv =====
// types and constants of the per-sender chunk sequence table
package pscst_pkg;

    localparam int TABLE_ENTRIES = 8;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int ADDR_W = 32;
    localparam int PORT_W = 16;
    localparam int KEY_W = ADDR_W + PORT_W;
    localparam int CNT_W = 32;
    localparam int SLOT_W = 3;

    // result codes
    typedef enum logic [2:0] {
        ST_TABLE_FULL = 3'd0,
        ST_AHEAD      = 3'd1,
        ST_OLD_ACK    = 3'd2,
        ST_ACCEPTED   = 3'd3,
        ST_LAST_FREED = 3'd4
    } t_status;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE
    } t_state;

    // one datagram header word
    typedef struct packed {
        logic [ADDR_W-1:0]       src_addr;
        logic [PORT_W-1:0]       src_port;
        logic signed [CNT_W-1:0] chunk_number;
        logic                    last_chunk;
    } t_in;

    // one result word
    typedef struct packed {
        t_status                 status;
        logic [SLOT_W-1:0]       slot;
        logic signed [CNT_W-1:0] ack_chunk;
    } t_out;

    // one table entry held in memory
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] count;
    } t_entry;

    // memory access request from the sequencer
    typedef struct packed {
        logic [IDX_W-1:0] rd_addr;
        logic             we;
        logic [IDX_W-1:0] wr_addr;
        t_entry           wr_data;
    } t_mem_req;

endpackage

// ===== rtl/core/pscst_mem.sv =====
// key and count memory, one write port, one registered read port
module pscst_mem (
    input  logic                i_clk,
    input  pscst_pkg::t_mem_req i_req,
    output pscst_pkg::t_entry   o_rd_data
);

    pscst_pkg::t_entry r_mem [pscst_pkg::TABLE_ENTRIES];
    pscst_pkg::t_entry r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_req.rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/pscst_ctrl.sv =====
// scan and update sequencer with slot free flags
module pscst_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  pscst_pkg::t_in      i_in,
    output logic                o_strobe,
    output pscst_pkg::t_out     o_out,
    output pscst_pkg::t_mem_req o_req,
    input  pscst_pkg::t_entry   i_rd_data
);

    localparam logic [pscst_pkg::IDX_W-1:0] LAST_IDX =
        pscst_pkg::IDX_W'(pscst_pkg::TABLE_ENTRIES - 1);

    pscst_pkg::t_state r_state, n_state;

    pscst_pkg::t_in                  r_in, n_in;
    logic [pscst_pkg::IDX_W-1:0]     r_idx, n_idx;
    logic [pscst_pkg::TABLE_ENTRIES-1:0] r_free, n_free;
    logic                            r_found, n_found;
    logic [pscst_pkg::IDX_W-1:0]     r_hit_idx, n_hit_idx;
    logic                            r_free_any, n_free_any;
    logic [pscst_pkg::IDX_W-1:0]     r_free_idx, n_free_idx;
    logic [pscst_pkg::CNT_W-1:0]     r_count, n_count;
    logic                            r_strobe, n_strobe;
    pscst_pkg::t_out                 r_out, n_out;

    logic [pscst_pkg::IDX_W-1:0]     w_slot;
    logic                            w_full;
    logic [pscst_pkg::CNT_W:0]       w_next;
    logic [pscst_pkg::CNT_W:0]       w_chunk;
    logic                            w_ahead;
    logic                            w_equal;
    logic [pscst_pkg::KEY_W-1:0]     w_key;

    assign w_key = {r_in.src_addr, r_in.src_port};
    assign w_slot = r_found ? r_hit_idx : r_free_idx;
    assign w_full = !r_found && !r_free_any;

    // count+1 and chunk compared in one extra bit, so no wrap
    assign w_next = {r_count[pscst_pkg::CNT_W-1], r_count} + (pscst_pkg::CNT_W+1)'(1);
    assign w_chunk = {r_in.chunk_number[pscst_pkg::CNT_W-1], r_in.chunk_number};
    assign w_ahead = $signed(w_chunk) > $signed(w_next);
    assign w_equal = w_chunk == w_next;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pscst_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free   <= '1;
            r_strobe <= 1'b0;
        end else begin
            r_free   <= n_free;
            r_strobe <= n_strobe;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_in       <= n_in;
        r_idx      <= n_idx;
        r_found    <= n_found;
        r_hit_idx  <= n_hit_idx;
        r_free_any <= n_free_any;
        r_free_idx <= n_free_idx;
        r_count    <= n_count;
        r_out      <= n_out;
    end

    // next state, scan and update
    always_comb begin
        n_state    = r_state;
        n_in       = r_in;
        n_idx      = r_idx;
        n_free     = r_free;
        n_found    = r_found;
        n_hit_idx  = r_hit_idx;
        n_free_any = r_free_any;
        n_free_idx = r_free_idx;
        n_count    = r_count;
        n_strobe   = 1'b0;
        n_out      = r_out;

        o_req.rd_addr         = r_idx + pscst_pkg::IDX_W'(1);
        o_req.we              = 1'b0;
        o_req.wr_addr         = w_slot;
        o_req.wr_data.key     = w_key;
        o_req.wr_data.count   = w_equal ? (r_count + pscst_pkg::CNT_W'(1)) : r_count;

        case (r_state)
            pscst_pkg::S_IDLE: begin
                // take a new word and read slot zero
                o_req.rd_addr = '0;
                if (start) begin
                    n_in       = i_in;
                    n_idx      = '0;
                    n_found    = 1'b0;
                    n_free_any = 1'b0;
                    n_free_idx = '0;
                    n_state    = pscst_pkg::S_SCAN;
                end
            end
            pscst_pkg::S_SCAN: begin
                // compare the slot whose entry just came out of memory
                if (!r_free[r_idx] && i_rd_data.key == w_key) begin
                    n_found   = 1'b1;
                    n_hit_idx = r_idx;
                    n_count   = i_rd_data.count;
                    n_state   = pscst_pkg::S_UPDATE;
                end else begin
                    if (r_free[r_idx]) begin
                        n_free_any = 1'b1;
                        n_free_idx = r_idx;
                    end
                    if (r_idx == LAST_IDX) begin
                        n_count = '0;
                        n_state = pscst_pkg::S_UPDATE;
                    end else begin
                        n_idx = r_idx + pscst_pkg::IDX_W'(1);
                    end
                end
            end
            pscst_pkg::S_UPDATE: begin
                // decide, write back and post the result
                n_strobe = 1'b1;
                n_state  = pscst_pkg::S_IDLE;
                if (w_full) begin
                    n_out.status    = pscst_pkg::ST_TABLE_FULL;
                    n_out.slot      = '0;
                    n_out.ack_chunk = '0;
                end else begin
                    o_req.we = !r_found || w_equal;
                    n_free[w_slot] = w_equal && r_in.last_chunk;
                    n_out.slot = pscst_pkg::SLOT_W'(w_slot);
                    if (w_ahead) begin
                        n_out.status    = pscst_pkg::ST_AHEAD;
                        n_out.ack_chunk = '0;
                    end else begin
                        n_out.ack_chunk = r_in.chunk_number;
                        if (w_equal) begin
                            n_out.status = r_in.last_chunk ? pscst_pkg::ST_LAST_FREED
                                                           : pscst_pkg::ST_ACCEPTED;
                        end else begin
                            n_out.status = pscst_pkg::ST_OLD_ACK;
                        end
                    end
                end
            end
            default: begin
                n_state = pscst_pkg::S_IDLE;
            end
        endcase
    end

    assign busy     = r_state != pscst_pkg::S_IDLE;
    assign o_strobe = r_strobe;
    assign o_out    = r_out;

endmodule

// ===== rtl/core/per_sender_chunk_sequence_table_top.sv =====
// top level of the per-sender chunk sequence table
// a header word is taken only while idle; the sequencer then scans the memory one slot
// per cycle from slot zero, stopping at a key hit or after the last slot, then decides,
// updates the slot where needed and posts the result, taking no new word while busy
// reset: synchronous active low, frees every slot; the receiver cannot stall
module per_sender_chunk_sequence_table_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  pscst_pkg::t_in  i_in,
    output logic            o_strobe,
    output pscst_pkg::t_out o_out
);

    pscst_pkg::t_mem_req w_req;
    pscst_pkg::t_entry   w_rd_data;

    // sequencer
    pscst_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_in      (i_in),
        .o_strobe  (o_strobe),
        .o_out     (o_out),
        .o_req     (w_req),
        .i_rd_data (w_rd_data)
    );

    // key and count storage
    pscst_mem u_mem (
        .i_clk     (i_clk),
        .i_req     (w_req),
        .o_rd_data (w_rd_data)
    );

endmodule

// ===== rtl/core/pscst_checker.sv =====
// port-level checks for the per-sender chunk sequence table
`include "assert_macros.svh"

module pscst_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            start,
    input logic            busy,
    input logic            o_strobe,
    input pscst_pkg::t_out o_out
);

    // an accepted word makes the block busy on the next cycle
    `ASSERT_CLK(a_accept_busy, i_clk, i_rst_n, (start && !busy) |=> busy)

    // a result appears only when the block has just finished a word
    `ASSERT_CLK(a_strobe_end, i_clk, i_rst_n, o_strobe |-> $fell(busy))

    // a dropped word for a full table carries zero slot and zero chunk
    `ASSERT_NEVER(a_full_zero, i_clk, i_rst_n,
        o_strobe && o_out.status == pscst_pkg::ST_TABLE_FULL &&
        (o_out.slot != '0 || o_out.ack_chunk != '0))

    // a chunk ahead of sequence is never echoed
    `ASSERT_NEVER(a_ahead_no_ack, i_clk, i_rst_n,
        o_strobe && o_out.status == pscst_pkg::ST_AHEAD && o_out.ack_chunk != '0)

endmodule

bind per_sender_chunk_sequence_table_top pscst_checker u_pscst_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_out    (o_out)
);

// ===== dv/pscst_checker.sv =====
// checker for the per-sender chunk sequence table: predicts each ack word and compares
`timescale 1ns / 1ps

module pscst_tb_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_busy,
    input  pscst_pkg::t_in  i_in,
    input  logic            i_strobe,
    input  pscst_pkg::t_out i_out,
    output int              o_errors,
    output int              o_pending,
    output int              o_results,
    output logic [4:0]      o_codes_seen
);

    // shadow copy of the sender table
    logic                        tbl_free  [pscst_pkg::TABLE_ENTRIES];
    logic [pscst_pkg::KEY_W-1:0] tbl_key   [pscst_pkg::TABLE_ENTRIES];
    logic [pscst_pkg::CNT_W-1:0] tbl_count [pscst_pkg::TABLE_ENTRIES];

    // ack words still owed by the block, oldest first
    pscst_pkg::t_out ack_due[$];
    pscst_pkg::t_out due;
    int   mismatches = 0;
    int   acks_seen = 0;
    logic [4:0] codes = '0;

    // look the sender up, claim or update its slot, and build the ack word
    function automatic pscst_pkg::t_out track_chunk(input pscst_pkg::t_in w);
        logic [pscst_pkg::KEY_W-1:0] key;
        logic signed [63:0]          chunk;
        logic signed [63:0]          next;
        int                          hit;
        int                          spare;
        pscst_pkg::t_out             r;
        key   = {w.src_addr, w.src_port};
        chunk = $signed(w.chunk_number);
        hit   = -1;
        spare = -1;
        r     = '0;
        // scan stops at the first occupied slot holding this key
        for (int i = 0; i < pscst_pkg::TABLE_ENTRIES; i++) begin
            if (hit < 0) begin
                if (tbl_free[i])
                    spare = i;
                else if (tbl_key[i] == key)
                    hit = i;
            end
        end
        // miss: take the highest free slot seen, or drop on a full table
        if (hit < 0 && spare >= 0) begin
            hit            = spare;
            tbl_free[hit]  = 1'b0;
            tbl_key[hit]   = key;
            tbl_count[hit] = '0;
        end
        if (hit < 0) begin
            r.status = pscst_pkg::ST_TABLE_FULL;
        end else begin
            r.slot = hit[pscst_pkg::SLOT_W-1:0];
            // count+1 compared in wide arithmetic so it never wraps
            next = $signed(tbl_count[hit]);
            next = next + 1;
            if (chunk > next) begin
                r.status = pscst_pkg::ST_AHEAD;
            end else begin
                r.ack_chunk = w.chunk_number;
                if (chunk == next) begin
                    tbl_count[hit] = tbl_count[hit] + 1'b1;
                    if (w.last_chunk) begin
                        tbl_free[hit] = 1'b1;
                        r.status = pscst_pkg::ST_LAST_FREED;
                    end else begin
                        r.status = pscst_pkg::ST_ACCEPTED;
                    end
                end else begin
                    r.status = pscst_pkg::ST_OLD_ACK;
                end
            end
        end
        return r;
    endfunction

    // compare outgoing acks, then predict for the header taken at this edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < pscst_pkg::TABLE_ENTRIES; j++) begin
                tbl_free[j]  = 1'b1;
                tbl_key[j]   = '0;
                tbl_count[j] = '0;
            end
            ack_due.delete();
        end else begin
            if (i_strobe) begin
                if (ack_due.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected ack word: status %0d slot %0d chunk %0d",
                                 i_out.status, i_out.slot, i_out.ack_chunk);
                    mismatches++;
                end else begin
                    due = ack_due.pop_front();
                    if (i_out.status !== due.status || i_out.slot !== due.slot ||
                        i_out.ack_chunk !== due.ack_chunk) begin
                        if (mismatches < 10)
                            $display(
                                "ack mismatch (status slot chunk): exp %0d %0d %0d, got %0d %0d %0d",
                                due.status, due.slot, due.ack_chunk,
                                i_out.status, i_out.slot, i_out.ack_chunk);
                        mismatches++;
                    end
                end
                acks_seen++;
                if (i_out.status <= pscst_pkg::ST_LAST_FREED)
                    codes[int'(i_out.status)] = 1'b1;
            end
            if (i_start && !i_busy)
                ack_due.push_back(track_chunk(i_in));
        end
        o_pending    <= ack_due.size();
        o_errors     <= mismatches;
        o_results    <= acks_seen;
        o_codes_seen <= codes;
    end

endmodule

// ===== dv/tb.sv =====
// testbench top: header stimulus, clock, reset and verdict for the chunk sequence table
`timescale 1ns / 1ps

module tb;

    localparam int POOL = 12;
    localparam int RANDOM_WORDS = 850;

    logic            i_clk;
    logic            i_rst_n;
    logic            start;
    logic            busy;
    pscst_pkg::t_in  i_in;
    logic            o_strobe;
    pscst_pkg::t_out o_out;

    int         errors;
    int         pending;
    int         results;
    logic [4:0] codes_seen;

    // sender pool and the chunk each sender is believed to be at
    logic [pscst_pkg::ADDR_W-1:0] pool_addr [POOL];
    logic [pscst_pkg::PORT_W-1:0] pool_port [POOL];
    int                hint [POOL];
    int                tag_due[$];
    int                tag_now;
    int                sent = 0;
    bit                burst = 1'b0;

    per_sender_chunk_sequence_table_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_in    (i_in),
        .o_strobe(o_strobe),
        .o_out   (o_out)
    );

    pscst_tb_checker u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_in        (i_in),
        .i_strobe    (o_strobe),
        .i_out       (o_out),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_results   (results),
        .o_codes_seen(codes_seen)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #5000000;
        $display("simulation failed");
        $finish;
    end

    // steer sender hints from acks: a dropped in-order chunk means the count is unknown
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe && tag_due.size() > 0) begin
            tag_now = tag_due.pop_front();
            if (tag_now >= 0 && tag_now[0] &&
                (o_out.status == pscst_pkg::ST_TABLE_FULL ||
                 o_out.status == pscst_pkg::ST_AHEAD))
                hint[tag_now >> 1] = 0;
        end
    end

    function automatic pscst_pkg::t_in make_word(input logic [31:0] addr,
                                                 input logic [15:0] port,
                                                 input logic [31:0] chunk,
                                                 input logic last);
        pscst_pkg::t_in w;
        w.src_addr     = addr;
        w.src_port     = port;
        w.chunk_number = chunk;
        w.last_chunk   = last;
        return w;
    endfunction

    // present one header word and hold it until taken
    task automatic send_word(input pscst_pkg::t_in w, input int tag);
        i_in  <= w;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        tag_due.push_back(tag);
        sent++;
    endtask

    // random idle after a word: mostly short, a few long, none in a burst
    task automatic idle_gap();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (burst || r < 50)
            n = 0;
        else if (r < 85)
            n = $urandom_range(1, 3);
        else if (r < 97)
            n = $urandom_range(4, 12);
        else
            n = $urandom_range(20, 60);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic send_plain(input logic [31:0] addr, input logic [15:0] port,
                              input logic [31:0] chunk, input logic last);
        send_word(make_word(addr, port, chunk, last), -1);
        idle_gap();
    endtask

    // hold off until every owed ack has come back
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // stimulus
    initial begin
        int         p;
        int         r;
        logic [31:0] chunk;
        logic       last;
        int         tag;
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_in    = '0;
        for (int i = 0; i < POOL; i++) begin
            pool_addr[i] = $urandom;
            pool_port[i] = 16'($urandom_range(0, 65535));
            hint[i]      = 0;
            // odd senders share the address of their neighbor, port differs
            if (i % 2 == 1) begin
                pool_addr[i] = pool_addr[i-1];
                pool_port[i] = pool_port[i-1] ^ (16'd1 << $urandom_range(0, 15));
            end
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: key and chunk extremes, old and ahead chunks, reuse of a freed slot
        send_plain(32'h0000_0000, 16'h0000, 32'd1, 1'b0);
        send_plain(32'h0000_0000, 16'h0000, 32'd1, 1'b0);
        send_plain(32'h0000_0000, 16'h0000, 32'h8000_0000, 1'b1);
        send_plain(32'h0000_0000, 16'h0000, 32'h7fff_ffff, 1'b0);
        // ahead chunk on a new sender keeps the claimed slot
        send_plain(32'hffff_ffff, 16'hffff, 32'd5, 1'b0);
        send_plain(32'hffff_ffff, 16'hffff, 32'd1, 1'b1);
        // freed slot no longer matches: reclaimed with a fresh count
        send_plain(32'hffff_ffff, 16'hffff, 32'd0, 1'b0);
        send_plain(32'h0000_0000, 16'hffff, 32'd1, 1'b0);
        send_plain(32'hffff_ffff, 16'h0000, 32'd1, 1'b0);
        for (int i = 0; i < 4; i++)
            send_plain(32'h0a00_0001 + i, 16'd5000, 32'd1, 1'b0);
        // every slot taken: new sender dropped
        send_plain(32'hc0a8_0101, 16'd9, 32'd1, 1'b0);
        send_plain(32'h0000_0000, 16'h0000, 32'd2, 1'b1);
        send_plain(32'hc0a8_0101, 16'd9, 32'hffff_ffff, 1'b0);
        send_plain(32'h0000_0000, 16'hffff, 32'd2, 1'b1);
        // release the directed senders so the random part starts with a clear table
        send_plain(32'hffff_ffff, 16'hffff, 32'd1, 1'b1);
        send_plain(32'hffff_ffff, 16'h0000, 32'd2, 1'b1);
        for (int i = 0; i < 4; i++)
            send_plain(32'h0a00_0001 + i, 16'd5000, 32'd2, 1'b1);
        send_plain(32'hc0a8_0101, 16'd9, 32'd1, 1'b1);
        drain();

        // random: mostly in-order chunk runs per sender, some old, ahead and noise
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 200 == 100)
                drain();
            if (n % 48 == 0)
                burst = ($urandom_range(0, 3) == 0);
            p = $urandom_range(0, POOL - 1);
            r = $urandom_range(0, 99);
            last = 1'($urandom_range(0, 1));
            tag = p * 2;
            if (r < 68) begin
                last  = ($urandom_range(0, 7) == 0);
                chunk = hint[p] + 1;
                hint[p] = last ? 0 : hint[p] + 1;
                tag   = p * 2 + 1;
            end else if (r < 78) begin
                if ($urandom_range(0, 1))
                    chunk = $urandom_range(0, hint[p]);
                else
                    chunk = 32'h8000_0000 | $urandom;
            end else if (r < 86) begin
                if ($urandom_range(0, 1))
                    chunk = hint[p] + 2 + $urandom_range(0, 3);
                else
                    chunk = $urandom & 32'h7fff_ffff;
            end else if (r < 94) begin
                chunk = $urandom;
            end else begin
                // one-shot stranger: claims a free slot, if any, and frees it at once
                send_word(make_word($urandom, 16'($urandom_range(0, 65535)), 32'd1, 1'b1),
                          -1);
                idle_gap();
                continue;
            end
            send_word(make_word(pool_addr[p], pool_port[p], chunk, last), tag);
            idle_gap();
        end

        drain();
        repeat (16) @(posedge i_clk);
        $display("covered %0d header words and %0d ack words", sent, results);
        $display("ack codes seen, one bit per code from table full upward: %05b", codes_seen);
        if (errors == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
